>>> rtl/rendezvous_message_controller_core_defines.svh
// Assertion helpers for the rendezvous controller.
`ifndef RENDEZVOUS_MESSAGE_CONTROLLER_CORE_DEFINES_SVH
`define RENDEZVOUS_MESSAGE_CONTROLLER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RMC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RMC_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMC_ASSERT(label, clk, rstn, prop, msg)
`define RMC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> rtl/rmc_pkg.sv
package rmc_pkg;
    localparam logic [1:0] MODE_SEND = 2'd0;
    localparam logic [1:0] MODE_RECV = 2'd1;
    localparam logic [1:0] MODE_NOTIFY = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;
    localparam logic [1:0] KIND_SPECIFIC = 2'd0;
    localparam logic [1:0] KIND_ANY = 2'd1;
    localparam logic [1:0] KIND_INTR = 2'd2;
    localparam logic [1:0] KIND_RSVD = 2'd3;
    localparam logic [2:0] ST_DELIVERED = 3'd0;
    localparam logic [2:0] ST_BLOCKED = 3'd1;
    localparam logic [2:0] ST_PENDED = 3'd2;
    localparam logic [2:0] ST_DEADLOCK = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;
    typedef enum logic [1:0] {
        SRC_PROC = 2'd0,
        SRC_ANY = 2'd1,
        SRC_INTR = 2'd2,
        SRC_NONE = 2'd3
    } src_kind_t;
    typedef struct packed {
        logic [2:0] status;
        logic [3:0] from_pid;
        logic       from_interrupt;
        logic [3:0] to_pid;
        logic [3:0] woken_pid;
        logic       woken_valid;
    } result_t;
endpackage

>>> rtl/rmc_walker.sv
// Pointer-chasing unit: one link followed per cycle while link_valid is high.
module rmc_walker #(
    parameter int NUM_PROCS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [$clog2(NUM_PROCS)-1:0] start_ptr,
    input  logic                         link_valid,
    input  logic [$clog2(NUM_PROCS)-1:0] link_ptr,
    output logic [$clog2(NUM_PROCS)-1:0] cur_ptr,
    output logic [$clog2(NUM_PROCS):0]   step_cnt
);
    localparam int PW = $clog2(NUM_PROCS);
    logic [PW-1:0] ptr_reg;
    logic [PW:0]   cnt_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            ptr_reg <= start_ptr;
            cnt_reg <= '0;
        end else if (link_valid) begin
            ptr_reg <= link_ptr;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end
    assign cur_ptr  = ptr_reg;
    assign step_cnt = cnt_reg;
endmodule

>>> rtl/rendezvous_message_controller_core.sv
// Flow: an accepted request passes S_DECIDE and then S_OUT for notify, invalid and immediate
// deliveries; a receive that dequeues a sender first walks the destination queue (S_QREM), a
// send the blocked-sender chain (S_CHAIN) and, if it blocks, the queue (S_QTAIL), one link per cycle.
// One request at a time: s_ready is low while an item runs; the next request is taken once
// the result loads into the output register, which happens later while that register still
// holds an untaken result.
// Reset (aresetn, synchronous, active low) clears all marks, empties all queues and
// drops any pending result.
module rendezvous_message_controller_core #(
    parameter int NUM_PROCS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [3:0] s_caller_pid,
    input  logic [3:0] s_peer_id,
    input  logic [1:0] s_peer_kind,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [3:0] m_from_pid,
    output logic       m_from_interrupt,
    output logic [3:0] m_to_pid,
    output logic [3:0] m_woken_pid,
    output logic       m_woken_valid
);
`include "rendezvous_message_controller_core_defines.svh"
    localparam int PW = $clog2(NUM_PROCS);

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_CHAIN, S_QTAIL, S_QREM, S_OUT
    } state_t;

    // Per-process state, kept in flip-flops (small depth).
    logic [NUM_PROCS-1:0] snd_reg, rcv_reg, irq_reg;
    logic [PW-1:0]        tgt_reg [NUM_PROCS];
    rmc_pkg::src_kind_t   srck_reg [NUM_PROCS];
    logic [PW-1:0]        srcp_reg [NUM_PROCS];
    logic [NUM_PROCS-1:0] hv_reg, nv_reg;   // head / next link valid
    logic [PW-1:0]        head_reg [NUM_PROCS];
    logic [PW-1:0]        nxt_reg  [NUM_PROCS];

    state_t           state_reg;
    logic [1:0]       mode_reg, kind_reg;
    logic [PW-1:0]    me_reg, peer_reg, from_reg, prev_reg;
    logic             prev_v_reg;
    logic             bad_reg;
    rmc_pkg::result_t res_reg;
    rmc_pkg::result_t out_reg;   // holds the offered result apart from the working one
    logic             m_valid_reg;

    // Walker shares one pointer register for chain, tail and remove walks.
    logic          w_start, w_link_v;
    logic [PW-1:0] w_start_ptr, w_link, w_ptr;
    logic [PW:0]   w_cnt;

    rmc_walker #(.NUM_PROCS(NUM_PROCS)) u_walk (
        .aclk(aclk), .aresetn(aresetn), .start(w_start), .start_ptr(w_start_ptr),
        .link_valid(w_link_v), .link_ptr(w_link), .cur_ptr(w_ptr), .step_cnt(w_cnt)
    );

    logic s_fire, m_fire, cnt_done;
    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign m_fire   = m_valid_reg && m_ready;
    assign cnt_done = (w_cnt >= (PW+1)'(NUM_PROCS - 1));

    // Decode checks on the incoming request.
    logic me_ok, peer_ok;
    assign me_ok   = (NUM_PROCS >= 16) || (s_caller_pid < 4'(NUM_PROCS));
    assign peer_ok = (NUM_PROCS >= 16) || (s_peer_id < 4'(NUM_PROCS));

    always_comb begin
        w_start     = 1'b0;
        w_start_ptr = peer_reg;
        w_link_v    = 1'b0;
        w_link      = tgt_reg[w_ptr];
        unique case (state_reg)
            S_DECIDE: begin
                w_start = 1'b1;
                if (mode_reg == rmc_pkg::MODE_RECV) w_start_ptr = head_reg[me_reg];
                else w_start_ptr = peer_reg;
            end
            S_CHAIN: begin
                w_link_v = 1'b1;
                w_link   = tgt_reg[w_ptr];
                if (!snd_reg[w_ptr] || tgt_reg[w_ptr] == me_reg || cnt_done) begin
                    w_link_v    = 1'b0;
                    w_start     = 1'b1;
                    w_start_ptr = head_reg[peer_reg];
                end
            end
            S_QTAIL, S_QREM: begin
                w_link   = nxt_reg[w_ptr];
                w_link_v = nv_reg[w_ptr] && !cnt_done &&
                           !(state_reg == S_QREM && w_ptr == from_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            snd_reg <= '0; rcv_reg <= '0; irq_reg <= '0;
            hv_reg  <= '0; nv_reg  <= '0;
            for (int i = 0; i < NUM_PROCS; i++) begin
                tgt_reg[i]  <= '0;
                srck_reg[i] <= rmc_pkg::SRC_NONE;
            end
        end else begin
            // Raise valid when the result loads, drop it once taken.
            if (state_reg == S_OUT && (!m_valid_reg || m_fire)) m_valid_reg <= 1'b1;
            else if (m_fire) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_fire) begin
                    mode_reg <= s_mode; kind_reg <= s_peer_kind;
                    me_reg   <= PW'(s_caller_pid); peer_reg <= PW'(s_peer_id);
                    bad_reg  <= (s_mode == rmc_pkg::MODE_RSVD) || !me_ok ||
                        (s_mode != rmc_pkg::MODE_NOTIFY &&
                         (s_peer_kind == rmc_pkg::KIND_RSVD ||
                          (s_peer_kind == rmc_pkg::KIND_SPECIFIC &&
                           (!peer_ok || s_peer_id == s_caller_pid)) ||
                          (s_mode == rmc_pkg::MODE_SEND &&
                           s_peer_kind != rmc_pkg::KIND_SPECIFIC)));
                    state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (bad_reg) begin
                        res_reg   <= '{rmc_pkg::ST_INVALID, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0};
                        state_reg <= S_OUT;
                    end else if (mode_reg == rmc_pkg::MODE_NOTIFY) begin
                        state_reg <= S_OUT;
                        if (rcv_reg[me_reg] && (srck_reg[me_reg] == rmc_pkg::SRC_INTR ||
                                                srck_reg[me_reg] == rmc_pkg::SRC_ANY)) begin
                            rcv_reg[me_reg]  <= 1'b0;
                            srck_reg[me_reg] <= rmc_pkg::SRC_NONE;
                            irq_reg[me_reg]  <= 1'b0;
                            res_reg <= '{rmc_pkg::ST_DELIVERED, 4'd0, 1'b1, 4'(me_reg),
                                         4'(me_reg), 1'b1};
                        end else begin
                            irq_reg[me_reg] <= 1'b1;
                            res_reg <= '{rmc_pkg::ST_PENDED, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0};
                        end
                    end else if (snd_reg[me_reg] || rcv_reg[me_reg]) begin
                        res_reg   <= '{rmc_pkg::ST_INVALID, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0};
                        state_reg <= S_OUT;
                    end else if (mode_reg == rmc_pkg::MODE_SEND) begin
                        state_reg <= S_CHAIN;
                    end else if (irq_reg[me_reg] && kind_reg != rmc_pkg::KIND_SPECIFIC) begin
                        irq_reg[me_reg] <= 1'b0;
                        res_reg <= '{rmc_pkg::ST_DELIVERED, 4'd0, 1'b1, 4'(me_reg),
                                     4'd0, 1'b0};
                        state_reg <= S_OUT;
                    end else if (kind_reg == rmc_pkg::KIND_ANY && hv_reg[me_reg]) begin
                        from_reg <= head_reg[me_reg]; prev_v_reg <= 1'b0;
                        state_reg <= S_QREM;
                    end else if (kind_reg == rmc_pkg::KIND_SPECIFIC &&
                                 snd_reg[peer_reg] && tgt_reg[peer_reg] == me_reg) begin
                        from_reg <= peer_reg; prev_v_reg <= 1'b0;
                        state_reg <= S_QREM;
                    end else begin
                        rcv_reg[me_reg] <= 1'b1;
                        srck_reg[me_reg] <= (kind_reg == rmc_pkg::KIND_ANY) ? rmc_pkg::SRC_ANY :
                                            (kind_reg == rmc_pkg::KIND_INTR) ?
                                            rmc_pkg::SRC_INTR : rmc_pkg::SRC_PROC;
                        srcp_reg[me_reg] <= peer_reg;
                        res_reg <= '{rmc_pkg::ST_BLOCKED, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0};
                        state_reg <= S_OUT;
                    end
                end
                S_CHAIN: begin
                    // Stop on a free process, a loop back to the caller, or the step limit.
                    if (snd_reg[w_ptr] && tgt_reg[w_ptr] == me_reg) begin
                        res_reg <= '{rmc_pkg::ST_DEADLOCK, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0};
                        state_reg <= S_OUT;
                    end else if (!snd_reg[w_ptr] || cnt_done) begin
                        if (rcv_reg[peer_reg] &&
                            ((srck_reg[peer_reg] == rmc_pkg::SRC_PROC &&
                              srcp_reg[peer_reg] == me_reg) ||
                             srck_reg[peer_reg] == rmc_pkg::SRC_ANY)) begin
                            rcv_reg[peer_reg]  <= 1'b0;
                            srck_reg[peer_reg] <= rmc_pkg::SRC_NONE;
                            res_reg <= '{rmc_pkg::ST_DELIVERED, 4'(me_reg), 1'b0,
                                         4'(peer_reg), 4'(peer_reg), 1'b1};
                            state_reg <= S_OUT;
                        end else begin
                            snd_reg[me_reg] <= 1'b1;
                            tgt_reg[me_reg] <= peer_reg;
                            nv_reg[me_reg]  <= 1'b0;
                            res_reg <= '{rmc_pkg::ST_BLOCKED, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0};
                            if (!hv_reg[peer_reg]) begin
                                hv_reg[peer_reg]   <= 1'b1;
                                head_reg[peer_reg] <= me_reg;
                                state_reg <= S_OUT;
                            end else begin
                                state_reg <= S_QTAIL;
                            end
                        end
                    end
                end
                S_QTAIL: if (!w_link_v) begin
                    // Caller's own next link was cleared above; append at the tail.
                    nv_reg[w_ptr]  <= 1'b1;
                    nxt_reg[w_ptr] <= me_reg;
                    state_reg <= S_OUT;
                end
                S_QREM: begin
                    if (w_ptr == from_reg || !w_link_v) begin
                        if (w_ptr == from_reg && hv_reg[me_reg]) begin
                            if (!prev_v_reg) begin
                                hv_reg[me_reg]   <= nv_reg[w_ptr];
                                head_reg[me_reg] <= nxt_reg[w_ptr];
                            end else begin
                                nv_reg[prev_reg]  <= nv_reg[w_ptr];
                                nxt_reg[prev_reg] <= nxt_reg[w_ptr];
                            end
                            nv_reg[w_ptr] <= 1'b0;
                        end
                        snd_reg[from_reg] <= 1'b0;
                        tgt_reg[from_reg] <= '0;
                        res_reg <= '{rmc_pkg::ST_DELIVERED, 4'(from_reg), 1'b0,
                                     4'(me_reg), 4'(from_reg), 1'b1};
                        state_reg <= S_OUT;
                    end else begin
                        prev_reg <= w_ptr; prev_v_reg <= 1'b1;
                    end
                end
                // Load the output register once it is free.
                S_OUT: if (!m_valid_reg || m_fire) begin
                    out_reg   <= res_reg;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = out_reg.status;
    assign m_from_pid       = out_reg.from_pid;
    assign m_from_interrupt = out_reg.from_interrupt;
    assign m_to_pid         = out_reg.to_pid;
    assign m_woken_pid      = out_reg.woken_pid;
    assign m_woken_valid    = out_reg.woken_valid;

    `RMC_ASSERT(a_one_request, aclk, aresetn, s_fire |=> !s_ready, "request overlap")
    `RMC_ASSERT(a_woken_only_delivered, aclk, aresetn,
        m_valid && m_woken_valid |-> m_status == rmc_pkg::ST_DELIVERED, "stray wake")
    `RMC_ASSERT(a_walk_bounded, aclk, aresetn,
        w_cnt <= (PW+1)'(NUM_PROCS), "walk overrun")
    `RMC_ASSERT_NR(a_reset_idle, aclk, !aresetn |=> state_reg == S_IDLE, "reset state")
endmodule

>>> tb/tb_rendezvous_message_controller_core.sv
module tb_rendezvous_message_controller_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROC = 16;
    localparam logic [4:0] LINK_END = 5'd16;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_mode;
    logic [3:0] s_caller_pid;
    logic [3:0] s_peer_id;
    logic [1:0] s_peer_kind;
    logic       m_valid;
    logic       m_ready;
    logic [2:0] m_status;
    logic [3:0] m_from_pid;
    logic       m_from_interrupt;
    logic [3:0] m_to_pid;
    logic [3:0] m_woken_pid;
    logic       m_woken_valid;

    rendezvous_message_controller_core #(.NUM_PROCS(NPROC)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_caller_pid(s_caller_pid), .s_peer_id(s_peer_id), .s_peer_kind(s_peer_kind),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_from_pid(m_from_pid), .m_from_interrupt(m_from_interrupt),
        .m_to_pid(m_to_pid), .m_woken_pid(m_woken_pid), .m_woken_valid(m_woken_valid)
    );

    // Shadow of the per-process rendezvous state.
    logic                snd_mark [NPROC];
    logic                rcv_mark [NPROC];
    logic [3:0]          snd_dest [NPROC];
    rmc_pkg::src_kind_t  rcv_kind [NPROC];
    logic [3:0]          rcv_pid  [NPROC];
    logic                irq_pend [NPROC];
    logic [4:0]          q_head   [NPROC];
    logic [4:0]          q_next   [NPROC];

    rmc_pkg::result_t expected_results[$];
    int      errors;
    int      idle_cycles;
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      hold_receiver;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic clear_shadow();
        for (int i = 0; i < NPROC; i++) begin
            snd_mark[i] = 1'b0; rcv_mark[i] = 1'b0; snd_dest[i] = 4'd0;
            rcv_kind[i] = rmc_pkg::SRC_NONE; rcv_pid[i] = 4'd0; irq_pend[i] = 1'b0;
            q_head[i] = LINK_END; q_next[i] = LINK_END;
        end
    endtask

    // Follow blocked senders from dest; true if the chain reaches src.
    function automatic bit sender_chain_closes(int src, int dest);
        int p;
        p = dest;
        for (int n = 0; n < NPROC; n++) begin
            if (p >= NPROC || !snd_mark[p]) return 0;
            if (snd_dest[p] == src) return 1;
            p = snd_dest[p];
        end
        return 0;
    endfunction

    task automatic enqueue_sender(int dest, int who);
        int p;
        p = q_head[dest];
        q_next[who] = LINK_END;
        if (p >= NPROC) begin
            q_head[dest] = 5'(who);
            return;
        end
        for (int n = 0; n < NPROC; n++) begin
            if (q_next[p] >= NPROC) break;
            p = q_next[p];
        end
        q_next[p] = 5'(who);
    endtask

    task automatic dequeue_sender(int owner, int who);
        int p;
        int prev;
        p = q_head[owner];
        prev = LINK_END;
        for (int n = 0; n < NPROC && p < NPROC; n++) begin
            if (p == who) begin
                if (prev >= NPROC) q_head[owner] = q_next[p];
                else q_next[prev] = q_next[p];
                q_next[p] = LINK_END;
                return;
            end
            prev = p;
            p = q_next[p];
        end
    endtask

    // Predict the outcome of one request and advance the shadow state.
    task automatic predict_rendezvous(input logic [1:0] mode, input logic [3:0] me,
                                      input logic [3:0] peer, input logic [1:0] kind);
        rmc_pkg::result_t r;
        int from;
        r = '0;
        if (mode == rmc_pkg::MODE_RSVD || int'(me) >= NPROC) begin
            r.status = rmc_pkg::ST_INVALID;
        end else if (mode == rmc_pkg::MODE_NOTIFY) begin
            if (rcv_mark[me] && (rcv_kind[me] == rmc_pkg::SRC_INTR ||
                                 rcv_kind[me] == rmc_pkg::SRC_ANY)) begin
                rcv_mark[me] = 1'b0; rcv_kind[me] = rmc_pkg::SRC_NONE; irq_pend[me] = 1'b0;
                r.status = rmc_pkg::ST_DELIVERED; r.from_interrupt = 1'b1;
                r.to_pid = me; r.woken_pid = me; r.woken_valid = 1'b1;
            end else begin
                irq_pend[me] = 1'b1;
                r.status = rmc_pkg::ST_PENDED;
            end
        end else if (snd_mark[me] || rcv_mark[me] || kind == rmc_pkg::KIND_RSVD ||
                     (kind == rmc_pkg::KIND_SPECIFIC && (int'(peer) >= NPROC || peer == me)) ||
                     (mode == rmc_pkg::MODE_SEND && kind != rmc_pkg::KIND_SPECIFIC)) begin
            r.status = rmc_pkg::ST_INVALID;
        end else if (mode == rmc_pkg::MODE_SEND) begin
            if (sender_chain_closes(me, peer)) begin
                r.status = rmc_pkg::ST_DEADLOCK;
            end else if (rcv_mark[peer] &&
                         ((rcv_kind[peer] == rmc_pkg::SRC_PROC && rcv_pid[peer] == me) ||
                          rcv_kind[peer] == rmc_pkg::SRC_ANY)) begin
                rcv_mark[peer] = 1'b0; rcv_kind[peer] = rmc_pkg::SRC_NONE;
                r.status = rmc_pkg::ST_DELIVERED; r.from_pid = me; r.to_pid = peer;
                r.woken_pid = peer; r.woken_valid = 1'b1;
            end else begin
                snd_mark[me] = 1'b1; snd_dest[me] = peer;
                enqueue_sender(peer, me);
                r.status = rmc_pkg::ST_BLOCKED;
            end
        end else if (irq_pend[me] &&
                     (kind == rmc_pkg::KIND_ANY || kind == rmc_pkg::KIND_INTR)) begin
            irq_pend[me] = 1'b0;
            r.status = rmc_pkg::ST_DELIVERED; r.from_interrupt = 1'b1; r.to_pid = me;
        end else begin
            from = LINK_END;
            if (kind == rmc_pkg::KIND_ANY) begin
                if (q_head[me] < NPROC) from = q_head[me];
            end else if (kind == rmc_pkg::KIND_SPECIFIC) begin
                if (snd_mark[peer] && snd_dest[peer] == me) from = peer;
            end
            if (from < NPROC) begin
                dequeue_sender(me, from);
                snd_mark[from] = 1'b0; snd_dest[from] = 4'd0;
                r.status = rmc_pkg::ST_DELIVERED; r.from_pid = 4'(from); r.to_pid = me;
                r.woken_pid = 4'(from); r.woken_valid = 1'b1;
            end else begin
                rcv_mark[me] = 1'b1;
                rcv_kind[me] = (kind == rmc_pkg::KIND_ANY) ? rmc_pkg::SRC_ANY :
                               (kind == rmc_pkg::KIND_INTR) ? rmc_pkg::SRC_INTR :
                               rmc_pkg::SRC_PROC;
                rcv_pid[me] = peer;
                r.status = rmc_pkg::ST_BLOCKED;
            end
        end
        expected_results.push_back(r);
    endtask

    // Offer one request, hold it until accepted, then predict it.
    task automatic send_request(input logic [1:0] mode, input logic [3:0] me,
                                input logic [3:0] peer, input logic [1:0] kind);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode; s_caller_pid <= me; s_peer_id <= peer; s_peer_kind <= kind;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_rendezvous(mode, me, peer, kind);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (2 * NPROC + 8) @(posedge aclk);
    endtask

    // Receiver: stall at random, or hold off for a long stretch on request.
    initial begin
        int held;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_receiver) begin
                m_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge aclk);
                hold_receiver = 0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
                @(posedge aclk);
            end
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        rmc_pkg::result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result status=%0d", m_status);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (m_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_status); errors++;
                end
                if (m_from_pid !== e.from_pid) begin
                    $error("from_pid exp %0d got %0d", e.from_pid, m_from_pid); errors++;
                end
                if (m_from_interrupt !== e.from_interrupt) begin
                    $error("from_interrupt exp %0d got %0d", e.from_interrupt,
                           m_from_interrupt); errors++;
                end
                if (m_to_pid !== e.to_pid) begin
                    $error("to_pid exp %0d got %0d", e.to_pid, m_to_pid); errors++;
                end
                if (m_woken_pid !== e.woken_pid) begin
                    $error("woken_pid exp %0d got %0d", e.woken_pid, m_woken_pid); errors++;
                end
                if (m_woken_valid !== e.woken_valid) begin
                    $error("woken_valid exp %0d got %0d", e.woken_valid, m_woken_valid);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake on either channel outside a receiver hold.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || hold_receiver) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(rmc_pkg::MODE_RSVD, 4'd0, 4'd0, rmc_pkg::KIND_SPECIFIC); // unused mode
        send_request(rmc_pkg::MODE_SEND, 4'd3, 4'd3, rmc_pkg::KIND_SPECIFIC); // to itself
        send_request(rmc_pkg::MODE_SEND, 4'd3, 4'd4, rmc_pkg::KIND_ANY);   // non-specific
        send_request(rmc_pkg::MODE_RECV, 4'd3, 4'd4, rmc_pkg::KIND_RSVD);  // bad kind
        send_request(rmc_pkg::MODE_SEND, 4'd0, 4'd15, rmc_pkg::KIND_SPECIFIC); // 0 on 15
        send_request(rmc_pkg::MODE_SEND, 4'd0, 4'd1, rmc_pkg::KIND_SPECIFIC);  // invalid, 0 already blocked
        send_request(rmc_pkg::MODE_SEND, 4'd15, 4'd0, rmc_pkg::KIND_SPECIFIC); // deadlock
        send_request(rmc_pkg::MODE_SEND, 4'd7, 4'd15, rmc_pkg::KIND_SPECIFIC); // second
        send_request(rmc_pkg::MODE_RECV, 4'd15, 4'd0, rmc_pkg::KIND_ANY);      // takes 0
        send_request(rmc_pkg::MODE_RECV, 4'd15, 4'd7, rmc_pkg::KIND_SPECIFIC); // takes 7
        send_request(rmc_pkg::MODE_NOTIFY, 4'd5, 4'd15, rmc_pkg::KIND_RSVD);   // pends
        send_request(rmc_pkg::MODE_NOTIFY, 4'd5, 4'd0, rmc_pkg::KIND_SPECIFIC); // stays
        send_request(rmc_pkg::MODE_RECV, 4'd5, 4'd0, rmc_pkg::KIND_INTR);  // takes pending
        send_request(rmc_pkg::MODE_RECV, 4'd5, 4'd0, rmc_pkg::KIND_INTR);  // blocks
        send_request(rmc_pkg::MODE_NOTIFY, 4'd5, 4'd0, rmc_pkg::KIND_SPECIFIC); // wakes it
        send_request(rmc_pkg::MODE_RECV, 4'd9, 4'd2, rmc_pkg::KIND_SPECIFIC); // blocks on 2
        send_request(rmc_pkg::MODE_SEND, 4'd2, 4'd9, rmc_pkg::KIND_SPECIFIC); // delivers
        send_request(rmc_pkg::MODE_RECV, 4'd8, 4'd0, rmc_pkg::KIND_ANY);
        send_request(rmc_pkg::MODE_NOTIFY, 4'd8, 4'd0, rmc_pkg::KIND_SPECIFIC);
        wait_drained();
    endtask

    // Random traffic, biased toward well-formed requests among few processes.
    task automatic test_random(int count, int s_pct, int r_pct);
        logic [1:0] mode;
        logic [1:0] kind;
        logic [3:0] me;
        logic [3:0] peer;
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 85) begin
                me = 4'($urandom_range(5)); peer = 4'($urandom_range(5));
                mode = 2'($urandom_range(2));
                kind = (mode == rmc_pkg::MODE_SEND) ? rmc_pkg::KIND_SPECIFIC :
                       2'($urandom_range(2));
            end else begin
                mode = 2'($urandom); me = 4'($urandom); peer = 4'($urandom);
                kind = 2'($urandom);
            end
            send_request(mode, me, peer, kind);
        end
        wait_drained();
    endtask

    // Long receiver hold-off while requests keep coming, then a drained pause.
    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_receiver = 1;
        for (int i = 0; i < 8; i++) begin
            send_request(rmc_pkg::MODE_NOTIFY, 4'($urandom), 4'd0, rmc_pkg::KIND_SPECIFIC);
        end
        wait_drained();
    endtask

    initial begin
        errors = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_receiver = 0;
        s_valid = 0; s_mode = 0; s_caller_pid = 0; s_peer_id = 0; s_peer_kind = 0;
        aresetn = 0;
        clear_shadow();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(500, 0, 0);
        test_random(500, 68, 0);
        test_backpressure();
        test_random(500, 0, 68);
        test_random(500, 28, 28);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/rmc_pkg.sv
rtl/rmc_walker.sv
rtl/rendezvous_message_controller_core.sv
tb/tb_rendezvous_message_controller_core.sv
